>>> hdl/assert_macros.svh
// Assertion macros for the checker file.
// Needs nothing else; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// next-cycle implication
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

>>> hdl/tqle_pkg.sv
// Shared types, constants and microcode encodings of the Q-learning engine.
// No dependencies.
`default_nettype none

package tqle_pkg;

  localparam int unsigned NUM_STATES_DEF = 128;
  localparam int unsigned NUM_MOVES_DEF  = 32;

  localparam int unsigned CFG_W     = 17;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned PC_W      = 5;

  localparam logic [CFG_W-1:0] Q_ONE = 17'd65536;

  localparam logic [CFG_W-1:0] RST_LEARNING_RATE = 17'd6554;
  localparam logic [CFG_W-1:0] RST_DISCOUNT      = 17'd58982;
  localparam logic [CFG_W-1:0] RST_START_EXPL    = 17'd65536;
  localparam logic [CFG_W-1:0] RST_FLOOR_EXPL    = 17'd3277;
  localparam logic [CFG_W-1:0] RST_DECAY_FACTOR  = 17'd65208;

  localparam logic [CFG_IDX_W-1:0] REG_LEARNING_RATE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DISCOUNT      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_START_EXPL    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_FLOOR_EXPL    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_DECAY_FACTOR  = 3'd4;

  localparam logic [1:0] ACT_SELECT = 2'd0;
  localparam logic [1:0] ACT_UPDATE = 2'd1;
  localparam logic [1:0] ACT_DECAY  = 2'd2;

  typedef struct packed {
    logic [1:0]         action;
    logic [6:0]         state_index;
    logic [6:0]         next_state_index;
    logic [4:0]         taken_move;
    logic [5:0]         move_count;
    logic signed [15:0] reward_value;
    logic [15:0]        random_fraction;
    logic [4:0]         random_pick;
  } in_item_t;

  typedef struct packed {
    logic [4:0]         picked_move;
    logic               picked_valid;
    logic               explored;
    logic signed [31:0] written_value;
    logic [16:0]        current_exploration;
  } out_item_t;

  typedef enum logic [3:0] {
    U_NOP,
    U_CLEAR,
    U_ACCEPT,
    U_SEL_START,
    U_SCAN,
    U_SEL_DONE,
    U_UPD_START,
    U_RD_ENTRY,
    U_MUL_GAMMA,
    U_TARGET,
    U_DIFF,
    U_MUL_ALPHA,
    U_WRITE,
    U_DEC_MUL,
    U_DEC_SET,
    U_EMIT
  } uop_t;

  typedef enum logic [3:0] {
    C_NEVER,
    C_ALWAYS,
    C_NO_BEAT,
    C_IS_SEL,
    C_IS_UPD,
    C_IS_DEC,
    C_SCAN_MORE,
    C_NO_SCAN,
    C_OUT_BUSY,
    C_CLR_MORE
  } cond_t;

  typedef struct packed {
    uop_t            uop;
    cond_t           cond;
    logic [PC_W-1:0] target;
  } ucode_t;

  typedef struct packed {
    uop_t uop;
  } ctl_t;

  typedef struct packed {
    logic       beat;
    logic [1:0] action;
    logic       no_scan;
    logic       scan_last;
    logic       clr_last;
    logic       out_free;
  } sts_t;

endpackage

`default_nettype wire

>>> hdl/tabular_q_learning_engine.sv
// One item is handled at a time; the next input beat is accepted once the result is registered.
// The row scan reads one table entry a cycle through the single memory read port.
// After reset a clearing pass zeroes every table entry with in_stall high; configuration
// writes are taken meanwhile. Config resets to defaults.
`default_nettype none

module tabular_q_learning_engine #(
  parameter int unsigned NUM_STATES = tqle_pkg::NUM_STATES_DEF,
  parameter int unsigned NUM_MOVES  = tqle_pkg::NUM_MOVES_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_valid,
  output logic                                in_stall,
  input  tqle_pkg::in_item_t                  in_data,
  output logic                                out_valid,
  input  wire logic                           out_stall,
  output tqle_pkg::out_item_t                 out_data,
  input  wire logic                           cfg_we,
  input  wire logic [tqle_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [tqle_pkg::CFG_W-1:0]     cfg_wdata
);
  import tqle_pkg::*;

  ctl_t ctl;
  sts_t sts;

  tqle_sequencer u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .sts   (sts),
    .ctl   (ctl)
  );

  tqle_datapath #(
    .NUM_STATES (NUM_STATES),
    .NUM_MOVES  (NUM_MOVES)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .ctl       (ctl),
    .sts       (sts)
  );

endmodule

`default_nettype wire

>>> hdl/tqle_sequencer.sv
// Microcode sequencer: program ROM, step counter and conditional jumps.
// Depends on tqle_pkg.
`default_nettype none

module tqle_sequencer (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  tqle_pkg::sts_t    sts,
  output tqle_pkg::ctl_t    ctl
);
  import tqle_pkg::*;

  localparam logic [PC_W-1:0] S_CLEAR     = 5'd0;
  localparam logic [PC_W-1:0] S_BOOT      = 5'd1;
  localparam logic [PC_W-1:0] S_SEL       = 5'd2;
  localparam logic [PC_W-1:0] S_SEL_SCAN  = 5'd3;
  localparam logic [PC_W-1:0] S_SEL_TAIL  = 5'd4;
  localparam logic [PC_W-1:0] S_SEL_DONE  = 5'd5;
  localparam logic [PC_W-1:0] S_UPD       = 5'd6;
  localparam logic [PC_W-1:0] S_UPD_SCAN  = 5'd7;
  localparam logic [PC_W-1:0] S_UPD_ENT   = 5'd8;
  localparam logic [PC_W-1:0] S_UPD_MG    = 5'd9;
  localparam logic [PC_W-1:0] S_UPD_TGT   = 5'd10;
  localparam logic [PC_W-1:0] S_UPD_DIFF  = 5'd11;
  localparam logic [PC_W-1:0] S_UPD_MA    = 5'd12;
  localparam logic [PC_W-1:0] S_UPD_WR    = 5'd13;
  localparam logic [PC_W-1:0] S_DEC_MUL   = 5'd14;
  localparam logic [PC_W-1:0] S_DEC_SET   = 5'd15;
  localparam logic [PC_W-1:0] S_EMIT      = 5'd19;
  localparam logic [PC_W-1:0] S_WAIT      = 5'd20;
  localparam logic [PC_W-1:0] S_DISP_SEL  = 5'd21;
  localparam logic [PC_W-1:0] S_DISP_UPD  = 5'd22;
  localparam logic [PC_W-1:0] S_DISP_DEC  = 5'd23;
  localparam logic [PC_W-1:0] S_DISP_NONE = 5'd24;

  function automatic ucode_t ucode_rom(input logic [PC_W-1:0] pc);
    ucode_t w;
    case (pc)
      S_CLEAR:     w = '{U_CLEAR,     C_CLR_MORE,  S_CLEAR};
      S_BOOT:      w = '{U_NOP,       C_ALWAYS,    S_WAIT};
      S_SEL:       w = '{U_SEL_START, C_NO_SCAN,   S_EMIT};
      S_SEL_SCAN:  w = '{U_SCAN,      C_SCAN_MORE, S_SEL_SCAN};
      S_SEL_TAIL:  w = '{U_NOP,       C_NEVER,     S_WAIT};
      S_SEL_DONE:  w = '{U_SEL_DONE,  C_ALWAYS,    S_EMIT};
      S_UPD:       w = '{U_UPD_START, C_NEVER,     S_WAIT};
      S_UPD_SCAN:  w = '{U_SCAN,      C_SCAN_MORE, S_UPD_SCAN};
      S_UPD_ENT:   w = '{U_RD_ENTRY,  C_NEVER,     S_WAIT};
      S_UPD_MG:    w = '{U_MUL_GAMMA, C_NEVER,     S_WAIT};
      S_UPD_TGT:   w = '{U_TARGET,    C_NEVER,     S_WAIT};
      S_UPD_DIFF:  w = '{U_DIFF,      C_NEVER,     S_WAIT};
      S_UPD_MA:    w = '{U_MUL_ALPHA, C_NEVER,     S_WAIT};
      S_UPD_WR:    w = '{U_WRITE,     C_ALWAYS,    S_EMIT};
      S_DEC_MUL:   w = '{U_DEC_MUL,   C_NEVER,     S_WAIT};
      S_DEC_SET:   w = '{U_DEC_SET,   C_ALWAYS,    S_EMIT};
      S_EMIT:      w = '{U_EMIT,      C_OUT_BUSY,  S_EMIT};
      S_WAIT:      w = '{U_ACCEPT,    C_NO_BEAT,   S_WAIT};
      S_DISP_SEL:  w = '{U_NOP,       C_IS_SEL,    S_SEL};
      S_DISP_UPD:  w = '{U_NOP,       C_IS_UPD,    S_UPD};
      S_DISP_DEC:  w = '{U_NOP,       C_IS_DEC,    S_DEC_MUL};
      S_DISP_NONE: w = '{U_NOP,       C_ALWAYS,    S_EMIT};
      default:     w = '{U_NOP,       C_ALWAYS,    S_WAIT};
    endcase
    return w;
  endfunction

  logic [PC_W-1:0] pc_r, pc_nxt;
  ucode_t          word;
  logic            take;

  assign word    = ucode_rom(pc_r);
  assign ctl.uop = word.uop;

  always_comb begin
    case (word.cond)
      C_NEVER:     take = 1'b0;
      C_ALWAYS:    take = 1'b1;
      C_NO_BEAT:   take = !sts.beat;
      C_IS_SEL:    take = (sts.action == ACT_SELECT);
      C_IS_UPD:    take = (sts.action == ACT_UPDATE);
      C_IS_DEC:    take = (sts.action == ACT_DECAY);
      C_SCAN_MORE: take = !sts.scan_last;
      C_NO_SCAN:   take = sts.no_scan;
      C_OUT_BUSY:  take = !sts.out_free;
      C_CLR_MORE:  take = !sts.clr_last;
      default:     take = 1'b0;
    endcase
    pc_nxt = take ? word.target : pc_r + 5'd1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= S_CLEAR;
    end else begin
      pc_r <= pc_nxt;
    end
  end

endmodule

`default_nettype wire

>>> hdl/tqle_datapath.sv
// Datapath: value table memory, row scan, multipliers, config registers, output register.
// Depends on tqle_pkg; driven by tqle_sequencer control words.
`default_nettype none

module tqle_datapath #(
  parameter int unsigned NUM_STATES = tqle_pkg::NUM_STATES_DEF,
  parameter int unsigned NUM_MOVES  = tqle_pkg::NUM_MOVES_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_valid,
  output logic                                in_stall,
  input  tqle_pkg::in_item_t                  in_data,
  output logic                                out_valid,
  input  wire logic                           out_stall,
  output tqle_pkg::out_item_t                 out_data,
  input  wire logic                           cfg_we,
  input  wire logic [tqle_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [tqle_pkg::CFG_W-1:0]     cfg_wdata,
  input  tqle_pkg::ctl_t                      ctl,
  output tqle_pkg::sts_t                      sts
);
  import tqle_pkg::*;

  localparam int unsigned DEPTH  = NUM_STATES * NUM_MOVES;
  localparam int unsigned ADDR_W = $clog2(DEPTH);
  localparam int unsigned ROW_W  = $clog2(NUM_STATES);
  localparam int unsigned MOVE_W = $clog2(NUM_MOVES);

  // index modulo a constant, restoring subtraction over seven bits
  function automatic logic [6:0] reduce7(input logic [6:0] x, input int unsigned n);
    logic [19:0] v;
    logic [19:0] d;
    v = {13'd0, x};
    for (int k = 6; k >= 0; k--) begin
      d = 20'(n << k);
      if (v >= d) v = v - d;
    end
    return v[6:0];
  endfunction

  logic signed [31:0] mem [DEPTH];

  in_item_t           in_r;
  logic [CFG_W-1:0]   alpha_r, gamma_r, floor_r, decay_r, eps_r;
  logic [MOVE_W-1:0]  idx_r, lim_r, rd_idx_r, best_idx_r;
  logic [ADDR_W-1:0]  base_r, ent_r, clr_r;
  logic               rd_vld_r;
  logic signed [31:0] rd_data_r, best_val_r, q_r;
  logic signed [49:0] prod1_r;
  logic signed [34:0] target_r;
  logic signed [35:0] diff_r;
  logic signed [53:0] prod2_r;
  logic [32:0]        prod3_r;
  logic [4:0]         res_pick_r;
  logic               res_pv_r, res_ex_r;
  logic signed [31:0] res_wr_r;
  logic               out_valid_r;
  out_item_t          out_r;

  logic               beat, out_free, explore, we;
  logic [ROW_W-1:0]   row_mod, nrow_mod;
  logic [MOVE_W-1:0]  move_mod;
  logic [8:0]         cnt9;
  logic [4:0]         pick_c;
  logic [ADDR_W-1:0]  ra, wa;
  logic signed [31:0] wd;
  logic signed [17:0] gamma_s, alpha_s;
  logic signed [49:0] prod1_c;
  logic signed [34:0] target_c;
  logic signed [35:0] diff_c;
  logic signed [53:0] prod2_c;
  logic [32:0]        prod3_c;
  logic signed [37:0] delta_c;
  logic signed [38:0] nq_c;
  logic signed [31:0] nq_sat;
  logic [CFG_W-1:0]   eps_dec, e_c, cfg_v;

  assign in_stall = (ctl.uop != U_ACCEPT);
  assign beat     = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;

  assign row_mod  = ROW_W'(reduce7(in_r.state_index, NUM_STATES));
  assign nrow_mod = ROW_W'(reduce7(in_r.next_state_index, NUM_STATES));
  assign move_mod = MOVE_W'(reduce7({2'b00, in_r.taken_move}, NUM_MOVES));

  assign cnt9    = ({3'b000, in_r.move_count} > 9'(NUM_MOVES)) ? 9'(NUM_MOVES)
                                                               : {3'b000, in_r.move_count};
  assign explore = ({1'b0, in_r.random_fraction} < eps_r);
  assign pick_c  = ({4'b0000, in_r.random_pick} < cnt9) ? in_r.random_pick
                                                        : 5'(cnt9 - 9'd1);

  assign gamma_s  = $signed({1'b0, gamma_r});
  assign alpha_s  = $signed({1'b0, alpha_r});
  assign prod1_c  = gamma_s * best_val_r;
  assign target_c = 35'($signed({in_r.reward_value, 16'h0000}))
                  + 35'($signed(prod1_r[49:16]));
  assign diff_c   = 36'(target_r) - 36'(q_r);
  assign prod2_c  = alpha_s * diff_r;
  assign prod3_c  = eps_r * decay_r;
  assign delta_c  = $signed(prod2_r[53:16]);
  assign nq_c     = 39'(q_r) + 39'(delta_c);

  always_comb begin
    if (nq_c[38:31] == '0 || nq_c[38:31] == '1) begin
      nq_sat = nq_c[31:0];
    end else if (nq_c[38]) begin
      nq_sat = 32'sh8000_0000;
    end else begin
      nq_sat = 32'sh7FFF_FFFF;
    end
  end

  assign e_c     = prod3_r[32:16];
  assign eps_dec = (e_c < floor_r) ? floor_r : e_c;
  assign cfg_v   = (cfg_wdata > Q_ONE) ? Q_ONE : cfg_wdata;

  // memory ports
  assign ra = (ctl.uop == U_RD_ENTRY) ? ent_r : base_r + ADDR_W'(idx_r);
  assign we = (ctl.uop == U_CLEAR) || (ctl.uop == U_WRITE);
  assign wa = (ctl.uop == U_CLEAR) ? clr_r : ent_r;
  assign wd = (ctl.uop == U_CLEAR) ? 32'sd0 : nq_sat;

  always_ff @(posedge clk) begin
    if (we) mem[wa] <= wd;
    rd_data_r <= mem[ra];
  end

  assign sts.beat      = beat;
  assign sts.action    = in_r.action;
  assign sts.no_scan   = (cnt9 == 9'd0) || explore;
  assign sts.scan_last = (idx_r == lim_r);
  assign sts.clr_last  = (clr_r == ADDR_W'(DEPTH - 1));
  assign sts.out_free  = out_free;

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      rd_vld_r    <= 1'b0;
      clr_r       <= '0;
      alpha_r     <= RST_LEARNING_RATE;
      gamma_r     <= RST_DISCOUNT;
      floor_r     <= RST_FLOOR_EXPL;
      decay_r     <= RST_DECAY_FACTOR;
      eps_r       <= RST_START_EXPL;
    end else begin
      rd_vld_r <= (ctl.uop == U_SCAN);
      if (ctl.uop == U_CLEAR) clr_r <= clr_r + 1'b1;
      if (ctl.uop == U_EMIT && out_free) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_we) begin
        case (cfg_index)
          REG_LEARNING_RATE: alpha_r <= cfg_v;
          REG_DISCOUNT:      gamma_r <= cfg_v;
          REG_START_EXPL:    eps_r   <= cfg_v;
          REG_FLOOR_EXPL:    floor_r <= cfg_v;
          REG_DECAY_FACTOR:  decay_r <= cfg_v;
          default: ;
        endcase
      end else if (ctl.uop == U_DEC_SET) begin
        eps_r <= eps_dec;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    rd_idx_r <= idx_r;
    if (rd_vld_r && (rd_idx_r == '0 || rd_data_r > best_val_r)) begin
      best_val_r <= rd_data_r;
      best_idx_r <= rd_idx_r;
    end
    case (ctl.uop)
      U_ACCEPT: begin
        if (beat) begin
          in_r       <= in_data;
          res_pick_r <= '0;
          res_pv_r   <= 1'b0;
          res_ex_r   <= 1'b0;
          res_wr_r   <= '0;
        end
      end
      U_SEL_START: begin
        idx_r  <= '0;
        lim_r  <= MOVE_W'(cnt9 - 9'd1);
        base_r <= ADDR_W'(row_mod * NUM_MOVES);
        if (cnt9 != 9'd0) begin
          res_pv_r <= 1'b1;
          if (explore) begin
            res_ex_r   <= 1'b1;
            res_pick_r <= pick_c;
          end
        end
      end
      U_SCAN:      idx_r <= idx_r + 1'b1;
      U_SEL_DONE:  res_pick_r <= 5'(best_idx_r);
      U_UPD_START: begin
        idx_r  <= '0;
        lim_r  <= MOVE_W'(NUM_MOVES - 1);
        base_r <= ADDR_W'(nrow_mod * NUM_MOVES);
        ent_r  <= ADDR_W'(row_mod * NUM_MOVES + move_mod);
      end
      U_MUL_GAMMA: begin
        prod1_r <= prod1_c;
        q_r     <= rd_data_r;
      end
      U_TARGET:    target_r <= target_c;
      U_DIFF:      diff_r   <= diff_c;
      U_MUL_ALPHA: prod2_r  <= prod2_c;
      U_WRITE:     res_wr_r <= nq_sat;
      U_DEC_MUL:   prod3_r  <= prod3_c;
      U_EMIT: begin
        if (out_free) begin
          out_r.picked_move         <= res_pick_r;
          out_r.picked_valid        <= res_pv_r;
          out_r.explored            <= res_ex_r;
          out_r.written_value       <= res_wr_r;
          out_r.current_exploration <= eps_r;
        end
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire

>>> hdl/tqle_checker.sv
// Port-level checker for the Q-learning engine, bound to the top level.
// Depends on tqle_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module tqle_checker (
  input wire logic          clk,
  input wire logic          rst_n,
  input wire logic          out_valid,
  input wire logic          out_stall,
  input tqle_pkg::out_item_t out_data
);

  `ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_data))
  `ASSERT_IMPLY(a_no_pick_zero, clk, rst_n, out_valid && !out_data.picked_valid, out_data.picked_move == 5'd0 && !out_data.explored)
  `ASSERT_IMPLY(a_explore_valid, clk, rst_n, out_valid && out_data.explored, out_data.picked_valid)
  `ASSERT_IMPLY(a_write_not_select, clk, rst_n, out_valid && out_data.written_value != 32'sd0, !out_data.picked_valid)
  `ASSERT_IMPLY(a_eps_range, clk, rst_n, out_valid, out_data.current_exploration <= 17'd65536)

endmodule

bind tabular_q_learning_engine tqle_checker u_tqle_checker (.*);

`default_nettype wire

>>> test/tb_tabular_q_learning_engine.sv
// Self-checking testbench for tabular_q_learning_engine: select, update and decay beats
// checked against an in-bench mirror of the Q-table and exploration rate.
// Depends on hdl/tqle_pkg.sv and hdl/tabular_q_learning_engine.sv.
`timescale 1ns / 100ps

module tb_tabular_q_learning_engine;
  import tqle_pkg::*;

  localparam logic [1:0] ACT_UNUSED = 2'd3;
  localparam logic [CFG_IDX_W-1:0] REG_OFF_LIST = 3'd7;
  localparam int ROW_W = 32;
  localparam int NDIR = 25;
  localparam int unsigned CYCLE_LIMIT = 600000;

  typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

  typedef struct {
    row_kind_t        kind;
    logic [2:0]       idx;
    logic [16:0]      val;
    in_item_t         item;
    bit               fixed;
    out_item_t        want;
  } step_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_item_t out_data;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0] cfg_wdata = '0;

  logic signed [31:0] q_mirror [0:NUM_STATES_DEF*NUM_MOVES_DEF-1];
  logic [16:0] eps_mirror, alpha_mirror, gamma_mirror, floor_mirror, decay_mirror;
  out_item_t pending_outcomes [$];
  out_item_t got_want;
  step_t dir_tab [0:NDIR-1];
  int errors = 0;
  int unsigned cycles = 0;
  int unsigned ostall_left = 0;
  int unsigned ostall_draw;
  bit calm = 1'b0;

  tabular_q_learning_engine i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always #5 clk = ~clk;

  function automatic in_item_t itm(logic [1:0] act, int st, int nst, int mv, int cnt,
                                   int rew, int frac, int pick);
    in_item_t r;
    r.action           = act;
    r.state_index      = st[6:0];
    r.next_state_index = nst[6:0];
    r.taken_move       = mv[4:0];
    r.move_count       = cnt[5:0];
    r.reward_value     = rew[15:0];
    r.random_fraction  = frac[15:0];
    r.random_pick      = pick[4:0];
    return r;
  endfunction

  function automatic out_item_t res(int mv, bit vld, bit ex, int wv, int eps);
    out_item_t r;
    r.picked_move         = mv[4:0];
    r.picked_valid        = vld;
    r.explored            = ex;
    r.written_value       = wv;
    r.current_exploration = eps[16:0];
    return r;
  endfunction

  function automatic step_t cfg_row(logic [2:0] idx, logic [16:0] val);
    return '{ROW_CFG, idx, val, '0, 1'b0, '0};
  endfunction

  function automatic step_t item_row(in_item_t it);
    return '{ROW_ITEM, REG_LEARNING_RATE, '0, it, 1'b0, '0};
  endfunction

  function automatic step_t chk_row(in_item_t it, out_item_t want);
    return '{ROW_ITEM, REG_LEARNING_RATE, '0, it, 1'b1, want};
  endfunction

  // mirror of one item: epsilon-greedy pick, Q update, epsilon decay
  function automatic out_item_t learn_and_pick(in_item_t it);
    out_item_t r;
    int unsigned cnt, best, a, base, idx;
    longint maxq, q, target, delta, nq, ga, al, rw;
    logic [33:0] prod;
    logic [16:0] nxt;
    r = '0;
    case (it.action)
      ACT_SELECT: begin
        cnt = it.move_count;
        if (cnt > NUM_MOVES_DEF) cnt = NUM_MOVES_DEF;
        if (cnt != 0) begin
          r.picked_valid = 1'b1;
          if ({1'b0, it.random_fraction} < eps_mirror) begin
            r.explored = 1'b1;
            r.picked_move = (it.random_pick < cnt) ? it.random_pick : 5'(cnt - 1);
          end else begin
            base = it.state_index * ROW_W;
            best = 0;
            for (a = 1; a < cnt; a++)
              if (q_mirror[base + a] > q_mirror[base + best]) best = a;
            r.picked_move = best[4:0];
          end
        end
      end
      ACT_UPDATE: begin
        base = it.next_state_index * ROW_W;
        maxq = q_mirror[base];
        for (a = 1; a < NUM_MOVES_DEF; a++)
          if (q_mirror[base + a] > maxq) maxq = q_mirror[base + a];
        idx = it.state_index * ROW_W + it.taken_move;
        q = q_mirror[idx];
        ga = gamma_mirror;
        al = alpha_mirror;
        rw = $signed(it.reward_value);
        target = rw * 65536 + ((ga * maxq) >>> 16);
        delta = (al * (target - q)) >>> 16;
        nq = q + delta;
        if (nq > 64'sd2147483647) nq = 64'sd2147483647;
        if (nq < -64'sd2147483648) nq = -64'sd2147483648;
        q_mirror[idx] = nq[31:0];
        r.written_value = nq[31:0];
      end
      ACT_DECAY: begin
        prod = eps_mirror * decay_mirror;
        nxt = prod[32:16];
        eps_mirror = (nxt < floor_mirror) ? floor_mirror : nxt;
      end
      default: ;
    endcase
    r.current_exploration = eps_mirror;
    return r;
  endfunction

  function automatic in_item_t rand_item();
    in_item_t it;
    int f;
    int unsigned sel;
    it = in_item_t'({$urandom, $urandom});
    sel = $urandom_range(0, 99);
    if (sel < 42) it.action = ACT_SELECT;
    else if (sel < 84) it.action = ACT_UPDATE;
    else if (sel < 94) it.action = ACT_DECAY;
    else it.action = ACT_UNUSED;
    if ($urandom_range(0, 9) != 0) it.move_count = 6'($urandom_range(1, 32));
    if ($urandom_range(0, 7) != 0) it.state_index = 7'($urandom_range(0, 15));
    if ($urandom_range(0, 7) != 0) it.next_state_index = 7'($urandom_range(0, 15));
    case ($urandom_range(0, 7))
      0: it.reward_value = -16'sd32768;
      1: it.reward_value = 16'sd32767;
      default: ;
    endcase
    if ($urandom_range(0, 3) == 0) begin
      f = int'(eps_mirror) - int'($urandom_range(0, 1));
      if (f > 65535) f = 65535;
      if (f < 0) f = 0;
      it.random_fraction = f[15:0];
    end
    return it;
  endfunction

  task automatic send_item(in_item_t it, bit fixed, out_item_t fixed_res);
    int unsigned gap;
    out_item_t pred;
    gap = calm ? 0 : $urandom_range(0, 6);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pred = learn_and_pick(it);
    pending_outcomes.push_back(fixed ? fixed_res : pred);
  endtask

  task automatic reg_write(logic [2:0] idx, logic [16:0] val);
    logic [16:0] v;
    v = (val > Q_ONE) ? Q_ONE : val;
    in_valid <= 1'b0;
    while (pending_outcomes.size() != 0) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    case (idx)
      REG_LEARNING_RATE: alpha_mirror = v;
      REG_DISCOUNT:      gamma_mirror = v;
      REG_START_EXPL:    eps_mirror = v;
      REG_FLOOR_EXPL:    floor_mirror = v;
      REG_DECAY_FACTOR:  decay_mirror = v;
      default: ;
    endcase
  endtask

  function automatic void cmp_field(string name, longint want, longint got);
    if (want != got) begin
      $display("%0t %s mismatch: expected %0d, actual %0d", $time, name, want, got);
      errors++;
    end
  endfunction

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_outcomes.size() == 0) begin
        $display("%0t unexpected result beat: expected none, actual %p", $time, out_data);
        errors++;
      end else begin
        got_want = pending_outcomes.pop_front();
        cmp_field("picked_move", got_want.picked_move, out_data.picked_move);
        cmp_field("picked_valid", got_want.picked_valid, out_data.picked_valid);
        cmp_field("explored", got_want.explored, out_data.explored);
        cmp_field("written_value", $signed(got_want.written_value),
                  $signed(out_data.written_value));
        cmp_field("current_exploration", got_want.current_exploration,
                  out_data.current_exploration);
      end
    end
  end

  // result-side back-pressure, drawn per accepted beat
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      ostall_left <= 0;
    end else if (ostall_left != 0) begin
      ostall_left <= ostall_left - 1;
      if (ostall_left == 1) out_stall <= 1'b0;
    end else if (out_valid && !out_stall) begin
      ostall_draw = calm ? 0 : $urandom_range(0, 6);
      if (ostall_draw != 0) begin
        out_stall <= 1'b1;
        ostall_left <= ostall_draw;
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    int k, ph, n, m;
    logic [16:0] vals [0:4];
    foreach (q_mirror[i]) q_mirror[i] = '0;
    alpha_mirror = RST_LEARNING_RATE;
    gamma_mirror = RST_DISCOUNT;
    eps_mirror   = RST_START_EXPL;
    floor_mirror = RST_FLOOR_EXPL;
    decay_mirror = RST_DECAY_FACTOR;

    dir_tab = '{
      chk_row(itm(ACT_SELECT, 0, 0, 0, 0, 0, 0, 0), res(0, 0, 0, 0, 65536)),
      chk_row(itm(ACT_SELECT, 3, 0, 0, 5, 0, 0, 31), res(4, 1, 1, 0, 65536)),
      chk_row(itm(ACT_SELECT, 127, 0, 0, 63, 0, 65535, 31), res(31, 1, 1, 0, 65536)),
      chk_row(itm(ACT_UNUSED, 127, 127, 31, 63, -1, 65535, 31), res(0, 0, 0, 0, 65536)),
      item_row(itm(ACT_UPDATE, 127, 0, 31, 0, 32767, 0, 0)),
      item_row(itm(ACT_UPDATE, 0, 127, 0, 0, -32768, 0, 0)),
      chk_row(itm(ACT_DECAY, 0, 0, 0, 0, 0, 0, 0), res(0, 0, 0, 0, 65208)),
      cfg_row(REG_START_EXPL, 17'd0),
      item_row(itm(ACT_SELECT, 127, 0, 0, 32, 0, 0, 0)),
      item_row(itm(ACT_SELECT, 0, 0, 0, 32, 0, 0, 0)),
      item_row(itm(ACT_SELECT, 127, 0, 0, 31, 0, 65535, 0)),
      cfg_row(REG_LEARNING_RATE, 17'h1FFFF),
      cfg_row(REG_DISCOUNT, Q_ONE),
      cfg_row(REG_OFF_LIST, 17'd1),
      item_row(itm(ACT_UPDATE, 5, 127, 3, 0, 32767, 0, 0)),
      item_row(itm(ACT_UPDATE, 5, 5, 3, 0, 32767, 0, 0)),
      cfg_row(REG_DECAY_FACTOR, 17'd0),
      cfg_row(REG_START_EXPL, Q_ONE),
      chk_row(itm(ACT_DECAY, 0, 0, 0, 0, 0, 0, 0), res(0, 0, 0, 0, 3277)),
      item_row(itm(ACT_SELECT, 5, 0, 0, 7, 0, 3276, 9)),
      item_row(itm(ACT_SELECT, 5, 0, 0, 7, 0, 3277, 9)),
      cfg_row(REG_FLOOR_EXPL, 17'd0),
      chk_row(itm(ACT_DECAY, 0, 0, 0, 0, 0, 0, 0), res(0, 0, 0, 0, 0)),
      cfg_row(REG_LEARNING_RATE, 17'd0),
      item_row(itm(ACT_UPDATE, 5, 0, 3, 0, -32768, 0, 0))
    };

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    for (k = 0; k < NDIR; k++) begin
      if (dir_tab[k].kind == ROW_CFG) begin
        reg_write(dir_tab[k].idx, dir_tab[k].val);
      end else begin
        cfg_we <= 1'b0;
        send_item(dir_tab[k].item, dir_tab[k].fixed, dir_tab[k].want);
      end
    end

    for (ph = 0; ph < 6; ph++) begin
      for (k = 0; k < 5; k++) begin
        case ($urandom_range(0, 4))
          0: vals[k] = '0;
          1: vals[k] = Q_ONE;
          2: vals[k] = 17'(65537 + $urandom_range(0, 65534));
          default: vals[k] = 17'($urandom_range(0, 65536));
        endcase
      end
      if (ph == 1) begin
        vals = '{Q_ONE, Q_ONE, Q_ONE, Q_ONE, Q_ONE};
      end else if (ph == 2) begin
        vals[1] = '0;
        vals[2] = '0;
        vals[3] = '0;
        vals[4] = '0;
      end
      reg_write(REG_LEARNING_RATE, vals[0]);
      reg_write(REG_DISCOUNT, vals[1]);
      reg_write(REG_START_EXPL, vals[2]);
      reg_write(REG_FLOOR_EXPL, vals[3]);
      reg_write(REG_DECAY_FACTOR, vals[4]);
      reg_write(REG_DECAY_FACTOR + 3'($urandom_range(1, 3)), 17'($urandom));
      cfg_we <= 1'b0;
      calm = (ph == 3);
      if (ph == 1) begin
        // drive one row fully negative, then update it twice more so those updates saturate low
        for (m = 0; m < NUM_MOVES_DEF + 2; m++)
          send_item(itm(ACT_UPDATE, 9, 9, m, 0, -32768, 0, 0), 1'b0, '0);
      end
      for (n = 0; n < 240; n++) begin
        if (ph != 3 && n % 40 == 0) calm = ($urandom_range(0, 3) == 0);
        send_item(rand_item(), 1'b0, '0);
      end
    end
    calm = 1'b0;

    in_valid <= 1'b0;
    while (pending_outcomes.size() != 0) @(posedge clk);
    repeat (NUM_MOVES_DEF + 16) @(posedge clk);
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
